@@ rtl/smsc_pkg.sv @@
`default_nettype none

package smsc_pkg;

  localparam int CHAR_W        = 8;
  localparam int LEN_W         = 6;
  localparam int REG_W         = 64;
  localparam int QUERY_REGS    = 4;
  localparam int CHARS_PER_REG = REG_W / CHAR_W;
  localparam int QUERY_STORED  = QUERY_REGS * CHARS_PER_REG;
  localparam int COUNT_W       = 9;
  localparam int SCORE_W       = 10;
  localparam int CFG_IDX_W     = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = 9'd511;
  localparam logic [COUNT_W-1:0] START_CAP    = 9'd400;
  localparam logic [SCORE_W-1:0] SCORE_NONE   = 10'd0;
  localparam logic [SCORE_W-1:0] SCORE_EMPTY  = 10'd1;
  localparam logic [SCORE_W-1:0] SCORE_EQUAL  = 10'd1000;
  localparam logic [SCORE_W-1:0] SCORE_PREFIX = 10'd800;
  localparam logic [SCORE_W-1:0] SCORE_BASE   = 10'd500;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_0_7    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_8_15   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_16_23  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_24_31  = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  // Fold A..Z to lower case, leave every other code alone.
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/substring_match_scorer.sv @@
`default_nettype none

// Substring match scorer.
// Input channel (in_valid_i / in_stall_o) carries one text byte per request
// with end_of_text_i and empty_text_i flags; a request with either flag set
// closes the text and produces one match_score_o on the output channel
// (out_valid_o / out_stall_i). The query lives in five registers written
// through cfg_we_i / cfg_index_i / cfg_data_i; the user must write them only
// while the block is idle; the block itself does not enforce this. Each text
// byte is compared in parallel by a row of cells, one per query character;
// each cell keeps one bit of the partial-match vector and hands it to its
// neighbor on each accepted byte, so one request (byte) is taken per clock
// while in_stall_o is low. The score reaches match_score_o via a register.
// A stalled output holds its score; one further score is absorbed by a skid
// register, after which in_stall_o rises until the output drains.
// Reset clears the query registers, the match state and both output valid bits.
module substring_match_scorer #(
  parameter int QUERY_MAX = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [smsc_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [smsc_pkg::CHAR_W-1:0]    text_byte_i,
  input  logic                          end_of_text_i,
  input  logic                          empty_text_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [smsc_pkg::SCORE_W-1:0]   match_score_o
);
  import smsc_pkg::*;

  localparam int NUM_CELLS = (QUERY_MAX < QUERY_STORED) ? QUERY_MAX : QUERY_STORED;

  logic [LEN_W-1:0]                 query_length_q;
  logic [QUERY_REGS-1:0][REG_W-1:0] query_q;

  logic [COUNT_W-1:0] bytes_seen_q, bytes_seen_d;
  logic               found_q, found_d;
  logic [COUNT_W-1:0] start_q, start_d;

  logic [LEN_W-1:0]     len_act;
  logic [CHAR_W-1:0]    byte_folded;
  logic                 in_acc, step, text_end, full;
  logic [NUM_CELLS-1:0] vec, vec_next, tail_sel;
  logic                 hit;
  logic [COUNT_W-1:0]   start_capped;
  logic [SCORE_W-1:0]   score;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_length_q <= '0;
      query_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_QUERY_LENGTH: query_length_q <= cfg_data_i[LEN_W-1:0];
        REG_QUERY_0_7:    query_q[0]     <= cfg_data_i;
        REG_QUERY_8_15:   query_q[1]     <= cfg_data_i;
        REG_QUERY_16_23:  query_q[2]     <= cfg_data_i;
        REG_QUERY_24_31:  query_q[3]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign len_act = (query_length_q > LEN_W'(NUM_CELLS)) ? LEN_W'(NUM_CELLS)
                                                        : query_length_q;

  assign in_stall_o  = full;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign text_end    = in_acc && (end_of_text_i || empty_text_i);
  assign step        = in_acc && !empty_text_i && (len_act != '0);
  assign byte_folded = fold_case(text_byte_i);

  // Row of match cells
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = vec[k-1];
    end

    assign tail_sel[k] = (len_act == LEN_W'(k + 1));

    smsc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (LEN_W'(k) < len_act),
      .step_i  (step),
      .clear_i (text_end),
      .prev_i  (prev),
      .qchar_i (query_q[k / CHARS_PER_REG][(k % CHARS_PER_REG) * CHAR_W +: CHAR_W]),
      .byte_i  (byte_folded),
      .bit_o   (vec[k]),
      .next_o  (vec_next[k])
    );
  end

  // Full query matched when the cell of the last query character fires.
  assign hit = |(vec_next & tail_sel);

  always_comb begin
    bytes_seen_d = bytes_seen_q;
    found_d      = found_q;
    start_d      = start_q;
    if (step && !found_q && hit) begin
      found_d = 1'b1;
      start_d = bytes_seen_q + COUNT_W'(1) - COUNT_W'(len_act);
    end
    if (in_acc && !empty_text_i && bytes_seen_q != COUNT_MAX) begin
      bytes_seen_d = bytes_seen_q + COUNT_W'(1);
    end
  end

  assign start_capped = (start_d > START_CAP) ? START_CAP : start_d;

  always_comb begin
    if (len_act == '0) begin
      score = SCORE_EMPTY;
    end else if (!found_d) begin
      score = SCORE_NONE;
    end else if (start_d == '0) begin
      score = (bytes_seen_d == COUNT_W'(len_act)) ? SCORE_EQUAL : SCORE_PREFIX;
    end else begin
      score = SCORE_BASE - SCORE_W'(start_capped);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      found_q      <= 1'b0;
      start_q      <= '0;
    end else if (text_end) begin
      bytes_seen_q <= '0;
      found_q      <= 1'b0;
      start_q      <= '0;
    end else begin
      bytes_seen_q <= bytes_seen_d;
      found_q      <= found_d;
      start_q      <= start_d;
    end
  end

  smsc_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (text_end),
    .push_score_i  (score),
    .full_o        (full),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_score_o (match_score_o)
  );

endmodule

`default_nettype wire

@@ rtl/smsc_cell.sv @@
`default_nettype none

module smsc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       step_i,
  input  logic                       clear_i,
  input  logic                       prev_i,
  input  logic [smsc_pkg::CHAR_W-1:0] qchar_i,
  input  logic [smsc_pkg::CHAR_W-1:0] byte_i,
  output logic                       bit_o,
  output logic                       next_o
);
  import smsc_pkg::*;

  logic bit_q, bit_d;

  // Prefix to here matches if the shorter one matched a byte ago and byte_i equals it.
  assign next_o = prev_i & en_i & (fold_case(qchar_i) == byte_i);

  always_comb begin
    bit_d = bit_q;
    if (step_i) begin
      bit_d = next_o;
    end
    if (clear_i) begin
      bit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

`default_nettype wire

@@ rtl/smsc_out_buf.sv @@
`default_nettype none

module smsc_out_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [smsc_pkg::SCORE_W-1:0] push_score_i,
  output logic                        full_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [smsc_pkg::SCORE_W-1:0] match_score_o
);
  import smsc_pkg::*;

  logic               out_valid_q, skid_valid_q;
  logic [SCORE_W-1:0] out_score_q, skid_score_q;
  logic               slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      // Hold the new request aside while the output is stalled.
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      out_score_q <= skid_valid_q ? skid_score_q : push_score_i;
    end else if (push_i) begin
      skid_score_q <= push_score_i;
    end
  end

  assign full_o        = skid_valid_q;
  assign out_valid_o   = out_valid_q;
  assign match_score_o = out_score_q;

endmodule

`default_nettype wire
